/* design/bsf_pkg.sv */
// Shared types and constants for the Bezier segment flattener.
package bsf_pkg;

    localparam int MAX_STEPS_DEF   = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int STEPS_RST       = 16;
    localparam int CFG_W           = 7;
    localparam int PT_W            = 16;
    localparam int T_W             = 16;

    typedef struct packed {
        logic                   func;
        logic signed [PT_W-1:0] p0_x;
        logic signed [PT_W-1:0] p0_y;
        logic signed [PT_W-1:0] p1_x;
        logic signed [PT_W-1:0] p1_y;
        logic signed [PT_W-1:0] p2_x;
        logic signed [PT_W-1:0] p2_y;
        logic signed [PT_W-1:0] p3_x;
        logic signed [PT_W-1:0] p3_y;
    } t_seg_in;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic                   last;
    } t_point_out;

endpackage

/* design/bsf_lerp.sv */
// Two-stage linear interpolation a + t*(b - a), truncated toward zero and saturated.
module bsf_lerp #(
    parameter int COORD_WIDTH = bsf_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic [bsf_pkg::T_W-1:0]       i_t,
    input  logic signed [COORD_WIDTH-1:0] i_a,
    input  logic signed [COORD_WIDTH-1:0] i_b,
    output logic signed [COORD_WIDTH-1:0] o_r
);
    import bsf_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = W + T_W + 2;
    localparam int NW = W + T_W + 3;
    localparam int QW = NW - T_W;

    logic signed [W:0]      w_diff;
    logic signed [T_W:0]    w_t;
    logic signed [PW-1:0]   w_p;
    logic signed [NW-1:0]   w_num;
    logic signed [NW-1:0]   w_adj;
    logic        [QW-1:0]   w_q;
    logic                   w_ovf;
    logic signed [W-1:0]    w_sat;

    logic signed [W-1:0]    r_a;
    logic signed [PW-1:0]   r_p;
    logic signed [W-1:0]    r_r;

    assign w_diff = {i_b[W-1], i_b} - {i_a[W-1], i_a};
    assign w_t    = $signed({1'b0, i_t});
    assign w_p    = w_diff * w_t;

    always_ff @(posedge i_clk) begin
        r_a <= i_a;
        r_p <= w_p;
    end

    // bias negatives before the shift so the quotient truncates toward zero
    assign w_num = {{3{r_a[W-1]}}, r_a, {T_W{1'b0}}} + {r_p[PW-1], r_p};
    assign w_adj = w_num + (w_num[NW-1] ? NW'({T_W{1'b1}}) : NW'(0));
    assign w_q   = w_adj[NW-1:T_W];

    assign w_ovf = ~(&w_q[QW-1:W-1]) & (|w_q[QW-1:W-1]);
    assign w_sat = w_q[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        r_r <= w_ovf ? w_sat : w_q[W-1:0];
    end

    assign o_r = r_r;

endmodule

/* design/bezier_segment_flattener.sv */
// Top level: steps sequencer, reciprocal divider and three-level de Casteljau pipeline.
// The receiver cannot stall: a taken segment's points come out one a cycle, in order.
// A segment of n points holds the issue stage for its n points; the next segment is
// taken in the cycle the last point is issued, unless a steps division is still running.
// A steps write starts a bit-serial division of 65536 by n, busy meanwhile.
// Reset (synchronous, active low): steps min(16, MAX_STEPS) and pipeline empty.
module bezier_segment_flattener #(
    parameter int MAX_STEPS   = bsf_pkg::MAX_STEPS_DEF,
    parameter int COORD_WIDTH = bsf_pkg::COORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  bsf_pkg::t_seg_in          i_seg,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [bsf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_valid,
    output bsf_pkg::t_point_out       o_point
);
    import bsf_pkg::*;

    localparam int W        = COORD_WIDTH;
    localparam int N_W      = $clog2(MAX_STEPS + 1);
    localparam int N_RST    = (STEPS_RST > MAX_STEPS) ? MAX_STEPS : STEPS_RST;
    localparam int DIV_BITS = T_W + 1;
    localparam int DC_W     = $clog2(DIV_BITS + 1);
    localparam int Q_RST    = 65536 / N_RST;
    localparam int R_RST    = 65536 % N_RST;

    // ---------------- input points, clamped to the coordinate width
    logic signed [PT_W-1:0] w_raw [2][4];
    logic signed [W-1:0]    w_in  [2][4];

    assign w_raw[0][0] = i_seg.p0_x;
    assign w_raw[1][0] = i_seg.p0_y;
    assign w_raw[0][1] = i_seg.p1_x;
    assign w_raw[1][1] = i_seg.p1_y;
    assign w_raw[0][2] = i_seg.p2_x;
    assign w_raw[1][2] = i_seg.p2_y;
    assign w_raw[0][3] = i_seg.p3_x;
    assign w_raw[1][3] = i_seg.p3_y;

    for (genvar ax = 0; ax < 2; ax++) begin : g_in_ax
        for (genvar k = 0; k < 4; k++) begin : g_in_pt
            if (W >= PT_W) begin : g_ext
                assign w_in[ax][k] = W'(w_raw[ax][k]);
            end else begin : g_clamp
                logic w_ovf;
                assign w_ovf = ~(&w_raw[ax][k][PT_W-1:W-1]) & (|w_raw[ax][k][PT_W-1:W-1]);
                assign w_in[ax][k] = w_ovf ?
                    (w_raw[ax][k][PT_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) :
                    w_raw[ax][k][W-1:0];
            end
        end
    end

    // ---------------- steps register and reciprocal divider
    logic [N_W-1:0]      r_n;
    logic [N_W-1:0]      r_nm1;
    logic [DIV_BITS-1:0] r_q;
    logic [N_W-1:0]      r_rem;
    logic [DC_W-1:0]     r_dcnt;

    logic [N_W-1:0]      w_cfg_n;
    logic [N_W:0]        w_trial;
    logic [N_W:0]        w_tsub;
    logic                w_ge;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_n = N_W'(1);
        end else if (i_cfg_data > CFG_W'(MAX_STEPS)) begin
            w_cfg_n = N_W'(MAX_STEPS);
        end else begin
            w_cfg_n = i_cfg_data[N_W-1:0];
        end
    end

    // dividend is 65536: only the first bit shifted in is a one
    assign w_trial = {r_rem, (r_dcnt == DC_W'(DIV_BITS))};
    assign w_ge    = w_trial >= {1'b0, r_n};
    assign w_tsub  = w_trial - {1'b0, r_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= N_W'(N_RST);
            r_nm1  <= N_W'(N_RST - 1);
            r_q    <= DIV_BITS'(Q_RST);
            r_rem  <= N_W'(R_RST);
            r_dcnt <= '0;
        end else if (i_cfg_we) begin
            r_n    <= w_cfg_n;
            r_nm1  <= w_cfg_n - N_W'(1);
            r_q    <= '0;
            r_rem  <= '0;
            r_dcnt <= DC_W'(DIV_BITS);
        end else if (r_dcnt != '0) begin
            r_q    <= {r_q[DIV_BITS-2:0], w_ge};
            r_rem  <= w_ge ? w_tsub[N_W-1:0] : w_trial[N_W-1:0];
            r_dcnt <= r_dcnt - DC_W'(1);
        end
    end

    // ---------------- point sequencer: t = floor(i*65536/n) by quotient/remainder steps
    logic                r_active;
    logic [N_W-1:0]      r_idx;
    logic [T_W-1:0]      r_tq;
    logic [N_W-1:0]      r_tr;
    logic                r_func;
    logic signed [W-1:0] r_pt [2][4];

    logic                w_last_issue;
    logic                w_accept;
    logic [N_W:0]        w_rsum;
    logic [N_W:0]        w_rsub;
    logic                w_rge;

    assign w_last_issue = (r_idx == r_nm1);
    assign busy         = (r_dcnt != '0) || (r_active && !w_last_issue);
    assign w_accept     = start && !busy;

    assign w_rsum = {1'b0, r_tr} + {1'b0, r_rem};
    assign w_rge  = w_rsum >= {1'b0, r_n};
    assign w_rsub = w_rsum - {1'b0, r_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_accept) begin
            r_active <= 1'b1;
        end else if (r_active && w_last_issue) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pt   <= w_in;
            r_func <= i_seg.func;
            r_idx  <= '0;
            r_tq   <= '0;
            r_tr   <= '0;
        end else if (r_active) begin
            r_idx <= r_idx + N_W'(1);
            r_tq  <= r_tq + r_q[T_W-1:0] + T_W'(w_rge);
            r_tr  <= w_rge ? w_rsub[N_W-1:0] : w_rsum[N_W-1:0];
        end
    end

    // ---------------- side-band pipeline: valid, last, t and segment kind
    logic [5:0]     r_vld;
    logic [5:0]     r_last;
    logic [1:0]     r_func_d;
    logic [T_W-1:0] r_t_d [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], r_active};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= {r_last[4:0], w_last_issue};
        r_func_d <= {r_func_d[0], r_func};
        r_t_d[0] <= r_tq;
        r_t_d[1] <= r_t_d[0];
        r_t_d[2] <= r_t_d[1];
        r_t_d[3] <= r_t_d[2];
    end

    // ---------------- de Casteljau levels
    logic signed [W-1:0] w_l1r [2][3];
    logic signed [W-1:0] w_l1  [2][3];
    logic signed [W-1:0] w_l2  [2][2];
    logic signed [W-1:0] w_l3  [2];

    for (genvar ax = 0; ax < 2; ax++) begin : g_ax
        for (genvar k = 0; k < 3; k++) begin : g_l1
            bsf_lerp #(.COORD_WIDTH(W)) u_lerp (
                .i_clk (i_clk),
                .i_t   (r_tq),
                .i_a   (r_pt[ax][k]),
                .i_b   (r_pt[ax][k+1]),
                .o_r   (w_l1r[ax][k])
            );
            // a line keeps p0..p1: feed it to every later input so it passes unchanged
            if (k == 0) begin : g_first
                assign w_l1[ax][k] = w_l1r[ax][k];
            end else begin : g_rest
                assign w_l1[ax][k] = r_func_d[1] ? w_l1r[ax][k] : w_l1r[ax][0];
            end
        end
        for (genvar k = 0; k < 2; k++) begin : g_l2
            bsf_lerp #(.COORD_WIDTH(W)) u_lerp (
                .i_clk (i_clk),
                .i_t   (r_t_d[1]),
                .i_a   (w_l1[ax][k]),
                .i_b   (w_l1[ax][k+1]),
                .o_r   (w_l2[ax][k])
            );
        end
        bsf_lerp #(.COORD_WIDTH(W)) u_lerp3 (
            .i_clk (i_clk),
            .i_t   (r_t_d[3]),
            .i_a   (w_l2[ax][0]),
            .i_b   (w_l2[ax][1]),
            .o_r   (w_l3[ax])
        );
    end

    assign o_valid         = r_vld[5];
    assign o_point.point_x = PT_W'(w_l3[0]);
    assign o_point.point_y = PT_W'(w_l3[1]);
    assign o_point.last    = r_last[5];

    // ---------------- checks
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("steps write did not raise busy");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_active && r_idx == '0))
        else $error("accepted segment did not start at point zero");

    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !w_last_issue) |=> r_active)
        else $error("segment run stopped before its last point");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_active, 6))
        else $error("output beat without a matching issued point");

endmodule
